// File: hw/rtl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg: shared definitions for the framed command receiver
// Frame length default, register indexes, command codes, decode kinds and
// the controller state type.
// ----------------------------------------------------------------------------
package fcr_pkg;

  // Default number of bytes in one frame
  localparam int unsigned FrameLenDef = 10;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE   = 1'd1;

  // Configuration reset values
  localparam logic [7:0] START_BYTE_RST = 8'hAA;
  localparam logic [7:0] END_BYTE_RST   = 8'h55;

  // Request operations
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  // Command codes found in frame byte 1
  localparam logic [7:0] CMD_PID   = 8'h11;
  localparam logic [7:0] CMD_ACCEL = 8'h12;

  // Decoded command kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_PID   = 2'd1;
  localparam logic [1:0] KIND_ACCEL = 2'd2;

  // First and last frame positions that the decode looks at
  localparam int unsigned DecFirst = 1;
  localparam int unsigned DecLast  = 7;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_ECHO
  } fcr_state_e;

endpackage

// File: hw/rtl/framed_command_receiver.sv
// ----------------------------------------------------------------------------
// framed_command_receiver: fixed-length frame receiver with start/end bytes
// Collects bytes into a frame buffer, then echoes a pending frame and decodes
// its command on the final echo.
// ----------------------------------------------------------------------------
// A byte request is stored straight into the frame buffer, a single-port-write
// synchronous RAM of FRAME_LEN bytes. A process request with a frame pending
// walks the buffer through its registered read port: each echo passes through
// the read register and then the output register, with one echo per cycle
// while the output side accepts. No new request is taken until the final echo
// is loaded into the output register. Bytes 1 to 7 are captured as they stream
// past, so the PID gains or acceleration are ready on the last echo. The buffer
// needs no clearing after reset.
module framed_command_receiver
  import fcr_pkg::*;
#(
  parameter int unsigned FRAME_LEN = fcr_pkg::FrameLenDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [fcr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [7:0]                  byte_in_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  echo_byte_o,
  output logic                        last_o,
  output logic [1:0]                  command_kind_o,
  output logic [15:0]                 gain_p_o,
  output logic [15:0]                 gain_i_o,
  output logic [15:0]                 gain_d_o,
  output logic [15:0]                 acceleration_o
);

  localparam int unsigned IdxW = $clog2(FRAME_LEN);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_LEN - 1);

  // Configuration registers
  logic [7:0] start_byte_q, end_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      end_byte_q   <= END_BYTE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_BYTE: start_byte_q <= cfg_data_i;
        CFG_END_BYTE:   end_byte_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Controller
  fcr_state_e state_q, state_d;
  logic       in_acc;
  logic       echo_load;
  logic       proc_start;

  logic [IdxW-1:0] byte_count_q, byte_count_d;
  logic            pending_q, pending_d;
  logic [IdxW-1:0] rd_addr_q, rd_addr_d;
  logic            out_valid_q, out_valid_d;

  assign in_acc     = in_valid_i && in_ready_o;
  assign proc_start = in_acc && (operation_i == OP_PROCESS) && pending_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (proc_start) state_d = ST_ECHO;
      end
      ST_ECHO: begin
        if (echo_load && rd_addr_q == LastIdx) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    echo_load  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_ECHO: echo_load  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Byte collection and pending mark
  logic byte_acc;
  logic mem_we;

  assign byte_acc = in_acc && (operation_i == OP_BYTE) && !pending_q;

  always_comb begin
    byte_count_d = byte_count_q;
    pending_d    = pending_q;
    mem_we       = 1'b0;
    if (byte_acc) begin
      if (byte_count_q == '0) begin
        if (byte_in_i == start_byte_q) begin
          mem_we       = 1'b1;
          byte_count_d = IdxW'(1);
        end
      end else begin
        mem_we = 1'b1;
        if (byte_count_q == LastIdx) begin
          byte_count_d = '0;
          pending_d    = (byte_in_i == end_byte_q);
        end else begin
          byte_count_d = byte_count_q + IdxW'(1);
        end
      end
    end
    if (proc_start) pending_d = 1'b0;
  end

  // Read address: presented from the next value so data tracks rd_addr_q
  always_comb begin
    rd_addr_d = rd_addr_q;
    if (proc_start) begin
      rd_addr_d = '0;
    end else if (echo_load && rd_addr_q != LastIdx) begin
      rd_addr_d = rd_addr_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      byte_count_q <= '0;
      pending_q    <= 1'b0;
      rd_addr_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      byte_count_q <= byte_count_d;
      pending_q    <= pending_d;
      rd_addr_q    <= rd_addr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Frame buffer
  logic [7:0] frame_mem_q [FRAME_LEN];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) frame_mem_q[byte_count_q] <= byte_in_i;
    rd_data_q <= frame_mem_q[rd_addr_d];
  end

  // Capture of decode bytes as they stream out
  logic [7:0] dec_q [DecFirst:DecLast];

  for (genvar g = DecFirst; g <= DecLast; g++) begin : g_dec
    always_ff @(posedge clk_i) begin
      if (echo_load && rd_addr_q == IdxW'(g)) dec_q[g] <= rd_data_q;
    end
  end

  // Output register
  logic        is_last;
  logic [1:0]  kind_d;
  logic [15:0] gp_d, gi_d, gd_d, acc_d;

  assign is_last = (rd_addr_q == LastIdx);

  always_comb begin
    kind_d = KIND_NONE;
    gp_d   = '0;
    gi_d   = '0;
    gd_d   = '0;
    acc_d  = '0;
    if (is_last) begin
      if (dec_q[1] == CMD_PID) begin
        kind_d = KIND_PID;
        gp_d   = {dec_q[2], dec_q[3]};
        gi_d   = {dec_q[4], dec_q[5]};
        gd_d   = {dec_q[6], dec_q[7]};
      end else if (dec_q[1] == CMD_ACCEL) begin
        kind_d = KIND_ACCEL;
        acc_d  = {dec_q[2], dec_q[3]};
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (echo_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  logic [7:0]  echo_q;
  logic        last_q;
  logic [1:0]  kind_q;
  logic [15:0] gp_q, gi_q, gd_q, acc_q;

  always_ff @(posedge clk_i) begin
    if (echo_load) begin
      echo_q <= rd_data_q;
      last_q <= is_last;
      kind_q <= kind_d;
      gp_q   <= gp_d;
      gi_q   <= gi_d;
      gd_q   <= gd_d;
      acc_q  <= acc_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign echo_byte_o    = echo_q;
  assign last_o         = last_q;
  assign command_kind_o = kind_q;
  assign gain_p_o       = gp_q;
  assign gain_i_o       = gi_q;
  assign gain_d_o       = gd_q;
  assign acceleration_o = acc_q;

endmodule
